>>> rtl/core/jlcg_pkg.sv
package jlcg_pkg;

	localparam int SEED_W      = 48;
	localparam int MUL_CHUNK_W = 12;
	localparam int MUL_CHUNKS  = 3;
	localparam int DIV_STEPS   = 31;

	localparam logic [SEED_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
	localparam logic [SEED_W-1:0] LCG_ADD  = 48'h0000_0000_000B;
	// multiplier padded to a whole number of chunks
	localparam logic [MUL_CHUNK_W*MUL_CHUNKS-1:0] LCG_MULT_EXT = 36'h5_DEEC_E66D;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_LOAD   = 3'd0;
	localparam kind_t KIND_TOP    = 3'd1;
	localparam kind_t KIND_BOUND  = 3'd2;
	localparam kind_t KIND_MINMAX = 3'd3;
	localparam kind_t KIND_LONG   = 3'd4;
	localparam kind_t KIND_DOUBLE = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_WAIT,
		ST_PROD,
		ST_POW,
		ST_DIV,
		ST_DWAIT,
		ST_CHECK
	} state_t;

endpackage

>>> rtl/core/jlcg_mul.sv
module jlcg_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] seed,
	output logic        done,
	output logic [47:0] next_seed
);
	import jlcg_pkg::*;

	logic                   run_q;
	logic                   done_q;
	logic [1:0]             cnt_q;
	logic [SEED_W-1:0]      seed_q;
	logic [SEED_W-1:0]      acc_q;
	logic [MUL_CHUNK_W-1:0] chunk;
	logic [SEED_W+MUL_CHUNK_W-1:0] prod;
	logic [SEED_W-1:0]      term;

	// seed * mult + add, one 12-bit slice of the multiplier per cycle
	always_comb begin
		chunk = LCG_MULT_EXT[cnt_q*MUL_CHUNK_W +: MUL_CHUNK_W];
		prod  = {{MUL_CHUNK_W{1'b0}}, seed_q} * {{SEED_W{1'b0}}, chunk};
		term  = prod[SEED_W-1:0] << (cnt_q * MUL_CHUNK_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 2'(MUL_CHUNKS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			seed_q <= seed;
			acc_q  <= LCG_ADD;
		end else if (run_q) begin
			acc_q <= acc_q + term;
		end
	end

	assign done      = done_q;
	assign next_seed = acc_q;

endmodule

>>> rtl/core/jlcg_div.sv
module jlcg_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);
	import jlcg_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [30:0] dvd_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic [31:0] rem_d;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[30]};
		diff  = trial - {1'b0, dvs_q};
		rem_d = diff[32] ? trial[31:0] : diff[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[29:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

>>> rtl/core/java_style_lcg_random_engine_core.sv
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+--------------------------
// request  | kind, seed_value, bit_count, bound, low_limit,     | taken when start && !busy
//          | high_limit                                         |
// result   | result_value                                       | one-cycle done strobe
//
// One item at a time. Each seed advance runs in the shared
// 12-bit-slice multiplier. A load finishes straight from idle; a top-bits
// or power-of-two draw takes one advance, a long or double needs a second
// one. Other bounds add a 31-step bit-serial remainder plus start and check
// states per attempt, and each rejection repeats the advance too.
// Reset clears the seed to zero. The receiver cannot stall: done is a pulse.
module java_style_lcg_random_engine_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  jlcg_pkg::kind_t     kind,
	input  logic [63:0]         seed_value,
	input  logic [5:0]          bit_count,
	input  logic [30:0]         bound,
	input  logic signed [30:0]  low_limit,
	input  logic signed [30:0]  high_limit,
	output logic                done,
	output logic signed [63:0]  result_value
);
	import jlcg_pkg::*;

	state_t             state_q, state_d;
	kind_t              kind_q;
	logic               second_q;
	logic [5:0]         bits_q;
	logic [31:0]        n_q;
	logic [31:0]        low_q;
	logic [30:0]        x_q;
	logic [31:0]        hi_q;
	logic signed [63:0] p_q;
	logic [63:0]        res_q;
	logic               done_q;
	logic [SEED_W-1:0]  lcg_q;

	logic               mul_start, mul_done;
	logic [SEED_W-1:0]  mul_next;
	logic               div_start, div_done;
	logic [31:0]        div_rem;

	logic               limits_flat;
	logic               pow2;
	logic [31:0]        low_add;
	logic [31:0]        chk;
	logic               accept;
	logic [5:0]         bits_eff;
	logic [SEED_W-1:0]  top_shift;
	logic [31:0]        pow_res;
	logic [31:0]        mod_res;
	logic [63:0]        long_res;

	jlcg_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mul_start),
		.seed      (lcg_q),
		.done      (mul_done),
		.next_seed (mul_next)
	);

	jlcg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (x_q),
		.divisor   (n_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		limits_flat = low_limit >= high_limit;
		pow2        = ((n_q - 32'd1) & n_q) == 32'd0;
		low_add     = (kind_q == KIND_MINMAX) ? low_q : 32'd0;
		// rejection test in 32-bit wrapping arithmetic
		chk         = {1'b0, x_q} - div_rem + (n_q - 32'd1);
		accept      = !chk[31];
		bits_eff    = (bits_q > 6'd32) ? 6'd32 : bits_q;
		top_shift   = mul_next >> (6'd48 - bits_eff);
		// arithmetic shift right by 31, low word
		pow_res     = p_q[62:31] + low_add;
		mod_res     = div_rem + low_add;
		long_res    = {hi_q, 32'd0} + {{32{mul_next[47]}}, mul_next[47:16]};
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_TOP, KIND_BOUND, KIND_LONG, KIND_DOUBLE: state_d = ST_ADV;
						KIND_MINMAX: state_d = limits_flat ? ST_IDLE : ST_ADV;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADV: begin
				mul_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (mul_done) begin
					case (kind_q)
						KIND_LONG, KIND_DOUBLE: state_d = second_q ? ST_IDLE : ST_ADV;
						KIND_BOUND, KIND_MINMAX: state_d = pow2 ? ST_PROD : ST_DIV;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PROD: state_d = ST_POW;
			ST_POW:  state_d = ST_IDLE;
			ST_DIV: begin
				div_start = 1'b1;
				state_d   = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = accept ? ST_IDLE : ST_ADV;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			lcg_q    <= '0;
			second_q <= 1'b0;
			kind_q   <= KIND_LOAD;
			bits_q   <= '0;
			n_q      <= '0;
			low_q    <= '0;
			x_q      <= '0;
			hi_q     <= '0;
			p_q      <= '0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q   <= kind;
						second_q <= 1'b0;
						bits_q   <= bit_count;
						low_q    <= {low_limit[30], low_limit};
						if (kind == KIND_MINMAX) begin
							n_q <= {high_limit[30], high_limit} - {low_limit[30], low_limit}
								+ 32'd1;
						end else begin
							n_q <= {1'b0, bound};
						end
						case (kind)
							KIND_LOAD: begin
								lcg_q  <= seed_value[SEED_W-1:0] ^ LCG_MULT;
								res_q  <= '0;
								done_q <= 1'b1;
							end
							KIND_MINMAX: begin
								if (limits_flat) begin
									res_q  <= {{33{low_limit[30]}}, low_limit};
									done_q <= 1'b1;
								end
							end
							KIND_TOP, KIND_BOUND, KIND_LONG, KIND_DOUBLE: ;
							default: begin
								res_q  <= '0;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_WAIT: begin
					if (mul_done) begin
						lcg_q <= mul_next;
						x_q   <= mul_next[47:17];
						case (kind_q)
							KIND_TOP: begin
								res_q  <= {{32{top_shift[31]}}, top_shift[31:0]};
								done_q <= 1'b1;
							end
							KIND_LONG: begin
								if (!second_q) begin
									hi_q     <= mul_next[47:16];
									second_q <= 1'b1;
								end else begin
									res_q  <= long_res;
									done_q <= 1'b1;
								end
							end
							KIND_DOUBLE: begin
								if (!second_q) begin
									hi_q     <= {6'd0, mul_next[47:22]};
									second_q <= 1'b1;
								end else begin
									res_q  <= {11'd0, hi_q[25:0], mul_next[47:21]};
									done_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PROD: begin
					p_q <= 64'($signed(n_q)) * 64'($signed({1'b0, x_q}));
				end
				ST_POW: begin
					res_q  <= {{32{pow_res[31]}}, pow_res};
					done_q <= 1'b1;
				end
				ST_CHECK: begin
					if (accept) begin
						res_q  <= {{32{mod_res[31]}}, mod_res};
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign result_value = res_q;

endmodule
